### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define PSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psc check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define PSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psc check failed");

`endif

### hw/rtl/psc_pkg.sv
// Shared types and constants for the positive sample channel mean block.
package psc_pkg;

    localparam int COLUMNS_DEF = 32;
    localparam int COL_W       = 5;
    localparam int SAMPLE_W    = 16;
    localparam int AVG_W       = 15;
    localparam int SUM_W       = 27;
    localparam int CNT_W       = 13;
    localparam int ACT_W       = 6;
    localparam int OUT_LIMIT   = 32;

    localparam logic [ACT_W-1:0] ACT_RESET = 6'd32;
    localparam logic [AVG_W-1:0] AVG_MAX   = 15'h7FFF;

    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_EMIT  = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_WR,
        ST_EM_RD,
        ST_EM_START,
        ST_EM_DIV
    } state_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic [COL_W-1:0]           column;
        logic signed [SAMPLE_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic [COL_W-1:0] out_column;
        logic [AVG_W-1:0] average;
        logic             last;
    } res_t;

endpackage

### hw/rtl/positive_sample_channel_mean.sv
// Top level of the per-channel mean of strictly positive samples.
//
// A request is taken when start is high and busy is low. An accumulate
// request (cmd CMD_ACCUM) with a positive sample and a column below COLUMNS
// does a read-modify-write of that channel's sum and count in the RAM and
// keeps busy high through its write-back state; any other
// accumulate request is dropped in its accept cycle. Sums saturate at
// 2^27-1 and counts at 2^13-1. An emit request (cmd CMD_EMIT) walks the
// channels 0 .. n-1, n = min(active_columns, COLUMNS, 32), and for each one
// runs the bit-serial divider on sum / count, one quotient bit per cycle.
// That divider sets the emit cost: each channel takes a RAM read, a divider
// load, one divide step per bit of the 27-bit sum and a hand-off. Each
// result appears on result for exactly one cycle with strobe high; the
// receiver cannot stall, so it must take every strobed result. The final
// result of an emit has last set and shows in the cycle in which busy
// falls, so the next request can already be taken then.
// An emit ends by clearing every sum and count at once through per-channel
// valid bits (no clearing pass, also none after reset); an emit with
// n = 0 gives no result and only clears. active_columns is written through
// the cfg channel, which is ready only while the block is idle.
module positive_sample_channel_mean #(
    parameter int COLUMNS = psc_pkg::COLUMNS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  psc_pkg::req_t              req,
    output logic                       strobe,
    output psc_pkg::res_t              result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [psc_pkg::ACT_W-1:0]  cfg_data
);

    localparam int AW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int LIM   = (COLUMNS < psc_pkg::OUT_LIMIT) ? COLUMNS : psc_pkg::OUT_LIMIT;
    localparam int SW    = psc_pkg::SUM_W;
    localparam int CW    = psc_pkg::CNT_W;
    localparam int ENT_W = SW + CW;
    localparam int IW    = psc_pkg::ACT_W;

    psc_pkg::state_t state_reg, state_next;

    psc_pkg::req_t   req_reg;
    logic [IW-1:0]   active_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   n_reg;
    logic [COLUMNS-1:0] valid_reg;
    logic            zero_reg;
    logic            strobe_reg;
    psc_pkg::res_t   res_reg;

    // FSM outputs
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic            ram_wr_en;
    logic            div_start;

    logic            accepted;
    logic            sample_ok;
    logic [IW-1:0]   n_now;
    logic            last_ch;

    logic [ENT_W-1:0] ram_rd_data;
    logic [ENT_W-1:0] ram_wr_data;
    logic [AW-1:0]    wr_addr;

    logic [SW-1:0]   old_sum;
    logic [CW-1:0]   old_cnt;
    logic [SW:0]     sum_ext;
    logic [SW-1:0]   new_sum;
    logic [CW-1:0]   new_cnt;
    logic            rd_valid;

    logic            div_done;
    logic [SW-1:0]   div_quo;
    logic [psc_pkg::AVG_W-1:0] avg_val;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    always_comb
    begin
        accepted  = start && (state_reg == psc_pkg::ST_IDLE);
        // positive: sign clear and not zero
        sample_ok = !req.sample[psc_pkg::SAMPLE_W-1] && (req.sample != '0)
                    && (32'(req.column) < COLUMNS);
        n_now     = (32'(active_reg) > LIM) ? IW'(LIM) : active_reg;
        last_ch   = ((idx_reg + IW'(1)) == n_reg);
    end

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (accepted)
                begin
                    if (req.cmd == psc_pkg::CMD_ACCUM)
                    begin
                        state_next = sample_ok ? psc_pkg::ST_ACC_WR : psc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = (n_now == '0) ? psc_pkg::ST_IDLE : psc_pkg::ST_EM_RD;
                    end
                end
            end
            psc_pkg::ST_ACC_WR:   state_next = psc_pkg::ST_IDLE;
            psc_pkg::ST_EM_RD:    state_next = psc_pkg::ST_EM_START;
            psc_pkg::ST_EM_START: state_next = psc_pkg::ST_EM_DIV;
            psc_pkg::ST_EM_DIV:
            begin
                if (div_done)
                begin
                    state_next = last_ch ? psc_pkg::ST_IDLE : psc_pkg::ST_EM_RD;
                end
            end
            default:              state_next = psc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State machine: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        busy        = 1'b1;
        cfg_ready   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(idx_reg);
        ram_wr_en   = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cfg_ready   = 1'b1;
                // read the channel now, so the write-back follows next cycle
                ram_rd_en   = accepted && (req.cmd == psc_pkg::CMD_ACCUM);
                ram_rd_addr = AW'(req.column);
            end
            psc_pkg::ST_ACC_WR:   ram_wr_en = 1'b1;
            psc_pkg::ST_EM_RD:    ram_rd_en = 1'b1;
            psc_pkg::ST_EM_START: div_start = 1'b1;
            psc_pkg::ST_EM_DIV:   busy      = 1'b1;
            default:              busy      = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Channel store: sum and count per channel, valid bit marks written
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_addr  = AW'(req_reg.column);
        // valid bit of the entry whose read data is on ram_rd_data now
        rd_valid = (state_reg == psc_pkg::ST_ACC_WR) ? valid_reg[wr_addr]
                                                     : valid_reg[AW'(idx_reg)];
        old_sum  = rd_valid ? ram_rd_data[ENT_W-1:CW] : '0;
        old_cnt  = rd_valid ? ram_rd_data[CW-1:0] : '0;
        sum_ext  = {1'b0, old_sum}
                 + (SW+1)'(req_reg.sample[psc_pkg::SAMPLE_W-2:0]);
        new_sum  = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
        new_cnt  = (old_cnt == {CW{1'b1}}) ? old_cnt : (old_cnt + CW'(1));
        ram_wr_data = {new_sum, new_cnt};
    end

    psc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (COLUMNS)
    ) u_psc_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    psc_div u_psc_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (old_sum),
        .divisor  (old_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    // quotient never exceeds the limit in practice, clamp anyway
    assign avg_val = zero_reg ? '0
                   : ((div_quo > SW'(psc_pkg::AVG_MAX)) ? psc_pkg::AVG_MAX
                   : div_quo[psc_pkg::AVG_W-1:0]);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= psc_pkg::ACT_RESET;
            valid_reg  <= '0;
            idx_reg    <= '0;
            n_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end

            strobe_reg <= (state_reg == psc_pkg::ST_EM_DIV) && div_done;

            if (accepted && (req.cmd == psc_pkg::CMD_EMIT))
            begin
                idx_reg <= '0;
                n_reg   <= n_now;
                if (n_now == '0)
                begin
                    valid_reg <= '0;
                end
            end
            else if ((state_reg == psc_pkg::ST_EM_DIV) && div_done)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (last_ch)
                begin
                    valid_reg <= '0;
                end
            end
            else if (state_reg == psc_pkg::ST_ACC_WR)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            req_reg <= req;
        end
        if (state_reg == psc_pkg::ST_EM_START)
        begin
            zero_reg <= (old_cnt == '0);
        end
        if ((state_reg == psc_pkg::ST_EM_DIV) && div_done)
        begin
            res_reg.out_column <= idx_reg[psc_pkg::COL_W-1:0];
            res_reg.average    <= avg_val;
            res_reg.last       <= last_ch;
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

### hw/rtl/psc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/psc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module psc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [psc_pkg::SUM_W-1:0]  dividend,
    input  logic [psc_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [psc_pkg::SUM_W-1:0]  quotient
);

    localparam int DW     = psc_pkg::SUM_W;
    localparam int VW     = psc_pkg::CNT_W;
    localparam int STEP_W = $clog2(DW + 1);

    // quo_reg shifts dividend bits out at the top and quotient bits in at the bottom
    logic [DW-1:0]     quo_reg;
    logic [VW-1:0]     rem_reg;
    logic [VW-1:0]     dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DW-1]};
        diff     = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = fits ? diff[VW-1:0] : rem_sh[VW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == STEP_W'(1));
            if (start)
            begin
                cnt_reg <= STEP_W'(DW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/psc_checker.sv
// Port-level checks on result timing of the channel mean block, with bind.
`include "assert_macros.svh"

module psc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          busy,
    input logic          strobe,
    input psc_pkg::res_t result
);

    // every result comes out of a divide that held the block busy
    `PSC_ASSERT_IMP(a_strobe_after_busy, strobe, $past(busy))

    // one divide per result: results never come back to back
    `PSC_ASSERT_NXT(a_strobe_spaced, strobe, !strobe)

    // the final result frees the block in the same cycle
    `PSC_ASSERT_IMP(a_last_frees, strobe && result.last, !busy)

    // more results pending while the emit is not done
    `PSC_ASSERT_IMP(a_mid_busy, strobe && !result.last, busy)

endmodule

bind positive_sample_channel_mean psc_checker u_psc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
